>>> rtl/core/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers for the Base64 codec
// Alphabet mapping, pad code and the structs passed between the group logic
// and the top level.
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
	localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
	localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;  // '0'
	localparam logic [7:0] CHAR_DIG_9 = 8'h39;  // '9'

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam int RES_MAX = 4;

	// Group accumulator: newest item sits in the low bits.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  fill;
		logic [1:0]  pad;
	} grp_state_t;

	// Results of one item, emitted in order data[0] .. data[count-1].
	typedef struct packed {
		logic [RES_MAX-1:0][7:0] data;
		logic [2:0]              count;
		logic                    last;
	} res_bundle_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) return CHAR_UC_A + w;
		if (v < 6'd52) return CHAR_LC_A + w - 8'd26;
		if (v < 6'd62) return CHAR_DIG_0 + w - 8'd52;
		if (v == 6'd62) return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	// Characters outside the alphabet map to zero.
	function automatic logic [5:0] b64_sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) d = c - CHAR_UC_A;
		else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) d = c - CHAR_LC_A + 8'd26;
		else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) d = c - CHAR_DIG_0 + 8'd52;
		else if (c == CHAR_PLUS) d = 8'd62;
		else if (c == CHAR_SLASH) d = 8'd63;
		return d[5:0];
	endfunction

endpackage

>>> rtl/core/b64_group.sv
// ----------------------------------------------------------------------------
// b64_group: per-item group logic
// Folds one byte or character into the group accumulator and forms the
// results it releases, for either direction.
// ----------------------------------------------------------------------------
module b64_group (
	input  logic                  direction,
	input  logic [7:0]            data_byte,
	input  logic                  last_item,
	input  b64_pkg::grp_state_t   state_cur,
	output b64_pkg::grp_state_t   state_nxt,
	output b64_pkg::res_bundle_t  result
);
	import b64_pkg::*;

	logic [2:0]  enc_fill;
	logic [23:0] enc_bits;
	logic [23:0] enc_word;
	logic [5:0]  sextet;
	logic [2:0]  pad_inc;
	logic [2:0]  fill_pad;
	logic        flush_en;
	logic [23:0] flush_bits;
	logic [2:0]  flush_k;
	logic [23:0] flush_word;
	grp_state_t  st;

	always_comb begin
		enc_fill   = {1'b0, state_cur.fill} + 3'd1;
		enc_bits   = {state_cur.bits[15:0], data_byte};
		enc_word   = enc_bits;
		sextet     = b64_sextet(data_byte);
		pad_inc    = (state_cur.pad == 2'd3) ? 3'd3 : {1'b0, state_cur.pad} + 3'd1;
		fill_pad   = {1'b0, state_cur.fill} + pad_inc;
		flush_en   = 1'b0;
		flush_bits = state_cur.bits;
		flush_k    = {1'b0, state_cur.fill};
		flush_word = 24'd0;
		st         = state_cur;
		result     = '0;
		result.last = last_item;

		if (direction == DIR_ENCODE) begin
			st.bits = enc_bits;
			st.fill = enc_fill[1:0];
			if (enc_fill == 3'd3 || last_item) begin
				case (enc_fill)
					3'd1:    enc_word = {data_byte, 16'd0};
					3'd2:    enc_word = {enc_bits[15:0], 8'd0};
					default: enc_word = enc_bits;
				endcase
				result.data[0] = b64_char(enc_word[23:18]);
				result.data[1] = b64_char(enc_word[17:12]);
				result.data[2] = (enc_fill >= 3'd2) ? b64_char(enc_word[11:6]) : CHAR_PAD;
				result.data[3] = (enc_fill >= 3'd3) ? b64_char(enc_word[5:0]) : CHAR_PAD;
				result.count   = 3'd4;
				st             = '0;
			end
		end else begin
			// At most one group is released per character.
			if (data_byte == CHAR_PAD) begin
				if (state_cur.fill >= 2'd2) begin
					st.pad = pad_inc[1:0];
					if (fill_pad >= 3'd4) begin
						flush_en = 1'b1;
						st       = '0;
					end
				end
			end else if (state_cur.pad != 2'd0) begin
				// data after padding closes the padded group first
				flush_en = 1'b1;
				st.bits  = {18'd0, sextet};
				st.fill  = 2'd1;
				st.pad   = 2'd0;
			end else if (state_cur.fill == 2'd3) begin
				flush_en   = 1'b1;
				flush_bits = {state_cur.bits[17:0], sextet};
				flush_k    = 3'd4;
				st         = '0;
			end else begin
				st.bits = {state_cur.bits[17:0], sextet};
				st.fill = state_cur.fill + 2'd1;
			end

			if (last_item && !flush_en) begin
				flush_en   = 1'b1;
				flush_bits = st.bits;
				flush_k    = {1'b0, st.fill};
			end

			case (flush_k)
				3'd2:    flush_word = {flush_bits[11:0], 12'd0};
				3'd3:    flush_word = {flush_bits[17:0], 6'd0};
				default: flush_word = flush_bits;
			endcase
			result.data[0] = flush_word[23:16];
			result.data[1] = flush_word[15:8];
			result.data[2] = flush_word[7:0];
			if (flush_en && flush_k >= 3'd2) result.count = flush_k - 3'd1;
		end

		if (last_item) st = '0;
		state_nxt = st;
	end

endmodule

>>> rtl/core/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec: streaming Base64 encoder / decoder (standard alphabet)
// The group logic forms an item's results from the input register, and they
// are registered in the result register, from which they transfer out.
// Throughput: one item per cycle into the input register if in_stall is low;
// results leave one per cycle through the result register while out_stall is
// low, and an item with results waits until the result register is free.
// Reset clears direction to encode and empties the group and both registers.
// ----------------------------------------------------------------------------
module base64_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_item,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       stream_end
);
	import b64_pkg::*;

	logic        dir_q;
	grp_state_t  grp_q;
	grp_state_t  grp_nxt;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	res_bundle_t res;
	res_bundle_t res_s2;
	logic        valid_s2;
	logic [1:0]  idx_q;
	logic        s2_free;
	logic        s1_go;
	logic        pop;
	logic        pop_last;

	b64_group u_group (
		.direction (dir_q),
		.data_byte (data_s1),
		.last_item (last_s1),
		.state_cur (grp_q),
		.state_nxt (grp_nxt),
		.result    (res)
	);

	assign cfg_ready  = 1'b1;
	assign out_valid  = valid_s2;
	assign out_byte   = res_s2.data[idx_q];
	assign run_end    = ({1'b0, idx_q} == res_s2.count - 3'd1);
	assign stream_end = run_end & res_s2.last;

	assign pop      = valid_s2 & ~out_stall;
	assign pop_last = pop & run_end;
	assign s2_free  = ~valid_s2 | pop_last;
	assign s1_go    = valid_s1 & ((res.count == 3'd0) | s2_free);
	assign in_stall = valid_s1 & ~s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
			grp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// a configuration write drops any partial group, even if direction is unchanged
			dir_q <= direction;
			grp_q <= '0;
		end else if (s1_go) begin
			grp_q <= grp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (s1_go && res.count != 3'd0) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (pop_last) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res.count != 3'd0) res_s2 <= res;
	end

endmodule
